>>> rtl/assert_macros.svh
// Assertion macros used by the RTL of the quadrant corner picker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at the clock's rising edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

>>> rtl/qcp_pkg.sv
// Package of the quadrant corner picker: coordinate widths, codes and transaction types
package qcp_pkg;

   localparam int COORD_INT_BITS  = 12;
   localparam int COORD_FRAC_BITS = 4;
   localparam int COORD_BITS      = COORD_INT_BITS + COORD_FRAC_BITS;
   localparam int DIM_BITS        = 12;
   localparam int DIM_FIX_BITS    = DIM_BITS + COORD_FRAC_BITS;
   localparam int EXT_BITS        = (COORD_BITS > DIM_FIX_BITS) ? COORD_BITS : DIM_FIX_BITS;
   localparam int DIST_BITS       = 2 * EXT_BITS + 1;

   localparam int NUM_QUAD    = 4;
   localparam int EARLY_DEPTH = 3;
   localparam int CSR_INDEX_BITS = 4;

   localparam logic [DIM_BITS-1:0] DIM_RESET = 12'd4095;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 4'd1;

   localparam logic [1:0] QUAD_TL = 2'd0;
   localparam logic [1:0] QUAD_TR = 2'd1;
   localparam logic [1:0] QUAD_BR = 2'd2;
   localparam logic [1:0] QUAD_BL = 2'd3;

   typedef struct packed {
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
      logic                  last_point;
   } point_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] corner_x;
      logic [COORD_BITS-1:0] corner_y;
      logic [1:0]            corner_quadrant;
      logic                  passed_through;
      logic                  last_corner;
   } result_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } coord_pair_type;

endpackage

>>> rtl/quadrant_corner_picker.sv
// Quadrant corner picker: keeps the nearest point per quadrant and emits the set's corners
// Latency: a point is registered at acceptance and folded into the quadrant state in the
// following cycle; the results of a set appear the cycle after its last point is registered.
// Throughput: one point per cycle; input stalls while the last point is folded in and while
// the set's one to four results drain through the output buffer, one per cycle while rsp_stall is low.
// Reset (synchronous, active high) clears the set count, quadrant flags and all valids,
// and sets image width and height to 4095.
`include "assert_macros.svh"

module quadrant_corner_picker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  qcp_pkg::point_type                req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output qcp_pkg::result_type               rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qcp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [qcp_pkg::DIM_BITS-1:0]      csr_data
);
   import qcp_pkg::*;

   logic [DIM_BITS-1:0] width_ff, height_ff;

   logic      in_valid_ff;
   point_type in_ff;

   logic [2:0]           seen_ff, seen_in;
   logic [NUM_QUAD-1:0]  filled_ff, filled_in, filled_new;
   coord_pair_type       early_ff [EARLY_DEPTH];
   coord_pair_type       best_ff  [NUM_QUAD];
   logic [DIST_BITS-1:0] dist_ff  [NUM_QUAD];

   result_type buf_ff [NUM_QUAD];
   result_type buf_in [NUM_QUAD];
   logic [2:0] count_ff, count_in;

   logic                  req_take, rsp_take, load;
   logic [EXT_BITS-1:0]   px, py, wf, hf, cx, cy, corner_x, corner_y, dx, dy;
   logic [2*EXT_BITS-1:0] dx_sq, dy_sq;
   logic                  lt_x, lt_y, take;
   logic [1:0]            quad;
   logic [DIST_BITS-1:0]  sq_dist;
   coord_pair_type        cur;
   coord_pair_type        best_new [NUM_QUAD];
   logic [2:0]            n, n_last;

   assign csr_ready = 1'b1;
   assign req_stall = (count_ff != 3'd0) || (in_valid_ff && in_ff.last_point);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign rsp_payload = buf_ff[0];
   assign load      = in_valid_ff && in_ff.last_point;

   // classify and measure the registered point
   always_comb begin
      px = EXT_BITS'(in_ff.point_x);
      py = EXT_BITS'(in_ff.point_y);
      wf = EXT_BITS'({width_ff, {COORD_FRAC_BITS{1'b0}}});
      hf = EXT_BITS'({height_ff, {COORD_FRAC_BITS{1'b0}}});
      cx = EXT_BITS'({1'b0, width_ff[DIM_BITS-1:1], {COORD_FRAC_BITS{1'b0}}});
      cy = EXT_BITS'({1'b0, height_ff[DIM_BITS-1:1], {COORD_FRAC_BITS{1'b0}}});
      lt_x = px < cx;
      lt_y = py < cy;
      if (lt_x && lt_y) begin
         quad = QUAD_TL;
      end else if (!lt_x && lt_y) begin
         quad = QUAD_TR;
      end else if (!lt_x && !lt_y) begin
         quad = QUAD_BR;
      end else begin
         quad = QUAD_BL;
      end
      corner_x = lt_x ? '0 : wf;
      corner_y = lt_y ? '0 : hf;
      dx = (px >= corner_x) ? px - corner_x : corner_x - px;
      dy = (py >= corner_y) ? py - corner_y : corner_y - py;
      dx_sq = (2*EXT_BITS)'(dx) * (2*EXT_BITS)'(dx);
      dy_sq = (2*EXT_BITS)'(dy) * (2*EXT_BITS)'(dy);
      sq_dist = {1'b0, dx_sq} + {1'b0, dy_sq};
      take = !filled_ff[quad] || (sq_dist < dist_ff[quad]);
      cur.x = in_ff.point_x;
      cur.y = in_ff.point_y;
      filled_new = filled_ff | (NUM_QUAD'(1) << quad);
      for (int i = 0; i < NUM_QUAD; i++) begin
         best_new[i] = (take && (quad == 2'(i))) ? cur : best_ff[i];
      end
   end

   // next set count and quadrant flags
   always_comb begin
      seen_in   = seen_ff;
      filled_in = filled_ff;
      if (in_valid_ff) begin
         if (in_ff.last_point) begin
            seen_in   = 3'd0;
            filled_in = '0;
         end else begin
            seen_in   = (seen_ff < 3'(NUM_QUAD)) ? seen_ff + 3'd1 : seen_ff;
            filled_in = filled_new;
         end
      end
   end

   // output buffer: load a whole set, else shift out one transaction per accept
   always_comb begin
      buf_in   = buf_ff;
      count_in = count_ff;
      n        = 3'd0;
      n_last   = 3'd0;
      if (load) begin
         for (int i = 0; i < NUM_QUAD; i++) begin
            buf_in[i] = '0;
         end
         if (seen_ff < 3'(EARLY_DEPTH)) begin
            for (int i = 0; i < EARLY_DEPTH; i++) begin
               if (3'(i) < seen_ff) begin
                  buf_in[i].corner_x       = early_ff[i].x;
                  buf_in[i].corner_y       = early_ff[i].y;
                  buf_in[i].passed_through = 1'b1;
               end
            end
            buf_in[seen_ff[1:0]].corner_x       = cur.x;
            buf_in[seen_ff[1:0]].corner_y       = cur.y;
            buf_in[seen_ff[1:0]].passed_through = 1'b1;
            buf_in[seen_ff[1:0]].last_corner    = 1'b1;
            count_in = seen_ff + 3'd1;
         end else begin
            for (int i = 0; i < NUM_QUAD; i++) begin
               if (filled_new[i]) begin
                  buf_in[n[1:0]].corner_x        = best_new[i].x;
                  buf_in[n[1:0]].corner_y        = best_new[i].y;
                  buf_in[n[1:0]].corner_quadrant = 2'(i);
                  n = n + 3'd1;
               end
            end
            n_last = n - 3'd1;
            buf_in[n_last[1:0]].last_corner = 1'b1;
            count_in = n;
         end
      end else if (rsp_take) begin
         for (int i = 0; i < NUM_QUAD - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= DIM_RESET;
         height_ff   <= DIM_RESET;
         in_valid_ff <= 1'b0;
         seen_ff     <= 3'd0;
         filled_ff   <= '0;
         count_ff    <= 3'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_IMAGE_WIDTH:  width_ff  <= csr_data;
               REG_IMAGE_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
         in_valid_ff <= req_take;
         seen_ff     <= seen_in;
         filled_ff   <= filled_in;
         count_ff    <= count_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_payload;
      end
      if (in_valid_ff) begin
         if (seen_ff < 3'(EARLY_DEPTH)) begin
            early_ff[seen_ff[1:0]] <= cur;
         end
         if (take) begin
            best_ff[quad] <= cur;
            dist_ff[quad] <= sq_dist;
         end
      end
      buf_ff <= buf_in;
   end

   `ASSERT_IMPLIES(a_no_point_while_draining, clock, reset, count_ff != 3'd0, !in_valid_ff, "point while draining")
   `ASSERT_NEXT(a_last_loads_results, clock, reset, load, count_ff != 3'd0, "last point gave no results")
   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= 3'(NUM_QUAD), "count beyond depth")
   `ASSERT_NEXT(a_last_empties_buffer, clock, reset, rsp_take && rsp_payload.last_corner, count_ff == 3'd0, "results left")

endmodule
